/* rtl/core/krl_pkg.sv */
`timescale 1ns / 1ps

package krl_pkg;

    // Field widths
    localparam int NOW_W      = 32;
    localparam int BYTES_W    = 16;
    localparam int KARMA_W    = 8;
    localparam int METER_W    = 32;
    localparam int STEP_W     = 7;
    localparam int HB_W       = 8;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_KARMA    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INC_STEP     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEC_STEP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PENALTY      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RESTORE      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_METER  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HEARTBEAT    = 3'd6;

    // Register reset values
    localparam logic [STEP_W-1:0]         RST_MAX_KARMA   = 7'd10;
    localparam logic [STEP_W-1:0]         RST_INC_STEP    = 7'd1;
    localparam logic [STEP_W-1:0]         RST_DEC_STEP    = 7'd1;
    localparam logic signed [KARMA_W-1:0] RST_PENALTY     = -8'sd5;
    localparam logic signed [KARMA_W-1:0] RST_RESTORE     = 8'sd5;
    localparam logic                      RST_CLEAR_METER = 1'b1;
    localparam logic [HB_W-1:0]           RST_HEARTBEAT   = 8'd2;

endpackage

/* rtl/core/karma_rate_limiter_top.sv */
`timescale 1ns / 1ps

// Karma rate limiter for one connection. Each request on the s_ side is one
// read (time in seconds, bytes read); each produces exactly one result on the
// m_ side with the updated karma, byte meter and a blocked flag. A new request
// is taken every clock cycle while the result stream is not back-pressured: the
// request is registered, the heartbeat regeneration and byte charge are evaluated
// combinationally against the state registers, and the result lands in an output
// register before m_tvalid rises, so sustained throughput is one request per cycle.
// That rate is set by the combinational karma/meter update loop. The user must
// write configuration registers through the cfg_ port only while idle; the block does not enforce it.
module karma_rate_limiter_top #(
    parameter int READ_FACTOR = 100,
    parameter int INIT_KARMA  = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [krl_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [krl_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [krl_pkg::S_TDATA_W-1:0]     s_tdata,   // now_seconds[31:0], byte_count[47:32]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [krl_pkg::M_TDATA_W-1:0]     m_tdata    // blocked[0], karma_now[8:1], meter_now[40:9]
);

    import krl_pkg::*;

    localparam int RF_W    = $clog2(READ_FACTOR + 1);
    localparam int PROD_W  = KARMA_W + RF_W + 1;
    localparam int CMP_W   = (PROD_W > METER_W + 1) ? PROD_W : METER_W + 1;
    localparam int PAD_W   = M_TDATA_W - 1 - KARMA_W - METER_W;
    localparam logic signed [RF_W:0]        RF_S       = (RF_W + 1)'(READ_FACTOR);
    localparam logic signed [KARMA_W-1:0]   INIT_K     = KARMA_W'(INIT_KARMA);

    // configuration registers
    logic [STEP_W-1:0]         cfg_max_reg;
    logic [STEP_W-1:0]         cfg_inc_reg;
    logic [STEP_W-1:0]         cfg_dec_reg;
    logic signed [KARMA_W-1:0] cfg_penalty_reg;
    logic signed [KARMA_W-1:0] cfg_restore_reg;
    logic                      cfg_clear_reg;
    logic [HB_W-1:0]           cfg_hb_reg;

    // input stage
    logic                      in_valid_reg;
    logic [NOW_W-1:0]          in_now_reg;
    logic [BYTES_W-1:0]        in_bytes_reg;

    // output stage
    logic                      out_valid_reg;
    logic                      out_blocked_reg;
    logic signed [KARMA_W-1:0] out_karma_reg;
    logic [METER_W-1:0]        out_meter_reg;

    // connection state
    logic signed [KARMA_W-1:0] karma_reg, karma_next;
    logic [METER_W-1:0]        meter_reg, meter_next;
    logic [NOW_W-1:0]          last_upd_reg, last_upd_next;
    logic                      ever_upd_reg, ever_upd_next;

    logic                      s_accept;
    logic                      commit;

    // datapath intermediates
    logic [NOW_W:0]            due;
    logic                      regen_go;
    logic signed [KARMA_W:0]   k_inc;
    logic                      over_restore;
    logic signed [KARMA_W-1:0] k_clip;
    logic signed [PROD_W-1:0]  drain_prod;
    logic [METER_W-1:0]        drain_val;
    logic [METER_W-1:0]        meter_drain;
    logic signed [KARMA_W-1:0] karma_rg;
    logic [METER_W-1:0]        meter_rg;
    logic [METER_W:0]          meter_sum;
    logic [METER_W-1:0]        meter_chg;
    logic signed [PROD_W-1:0]  allow_prod;
    logic signed [CMP_W-1:0]   meter_cmp;
    logic signed [CMP_W-1:0]   allow_cmp;
    logic                      overrun;
    logic signed [KARMA_W:0]   k_dec;

    // handshake
    assign commit   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || commit;
    assign s_accept = s_tvalid && s_tready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_max_reg     <= RST_MAX_KARMA;
            cfg_inc_reg     <= RST_INC_STEP;
            cfg_dec_reg     <= RST_DEC_STEP;
            cfg_penalty_reg <= RST_PENALTY;
            cfg_restore_reg <= RST_RESTORE;
            cfg_clear_reg   <= RST_CLEAR_METER;
            cfg_hb_reg      <= RST_HEARTBEAT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_KARMA:   cfg_max_reg     <= cfg_data[STEP_W-1:0];
                REG_INC_STEP:    cfg_inc_reg     <= cfg_data[STEP_W-1:0];
                REG_DEC_STEP:    cfg_dec_reg     <= cfg_data[STEP_W-1:0];
                REG_PENALTY:     cfg_penalty_reg <= $signed(cfg_data[KARMA_W-1:0]);
                REG_RESTORE:     cfg_restore_reg <= $signed(cfg_data[KARMA_W-1:0]);
                REG_CLEAR_METER: cfg_clear_reg   <= cfg_data[0];
                REG_HEARTBEAT:   cfg_hb_reg      <= cfg_data[HB_W-1:0];
                default: ;
            endcase
        end
    end

    // regeneration step
    always_comb begin
        due          = (NOW_W + 1)'(last_upd_reg) + (NOW_W + 1)'(cfg_hb_reg);
        regen_go     = !ever_upd_reg || (due <= {1'b0, in_now_reg});
        k_inc        = (KARMA_W + 1)'(karma_reg) + $signed({2'b00, cfg_inc_reg});
        over_restore = karma_reg[KARMA_W-1] && !k_inc[KARMA_W];
        if (k_inc > $signed({2'b00, cfg_max_reg})) begin
            k_clip = $signed({1'b0, cfg_max_reg});
        end else begin
            k_clip = k_inc[KARMA_W-1:0];
        end

        // drain the meter by positive karma times the read factor
        drain_prod = k_clip * RF_S;
        drain_val  = METER_W'(drain_prod);
        if (k_clip > 0) begin
            meter_drain = (meter_reg > drain_val) ? meter_reg - drain_val : '0;
        end else begin
            meter_drain = meter_reg;
        end

        if (regen_go) begin
            karma_rg = over_restore ? cfg_restore_reg : k_clip;
            meter_rg = (over_restore && cfg_clear_reg) ? '0 : meter_drain;
        end else begin
            karma_rg = karma_reg;
            meter_rg = meter_reg;
        end
    end

    // byte charge and overrun check
    always_comb begin
        meter_sum  = {1'b0, meter_rg} + (METER_W + 1)'(in_bytes_reg);
        meter_chg  = meter_sum[METER_W] ? '1 : meter_sum[METER_W-1:0];
        allow_prod = karma_rg * RF_S;
        meter_cmp  = $signed(CMP_W'({1'b0, meter_chg}));
        allow_cmp  = CMP_W'(allow_prod);
        overrun    = meter_cmp > allow_cmp;
        k_dec      = (KARMA_W + 1)'(karma_rg) - $signed({2'b00, cfg_dec_reg});
        if (overrun) begin
            karma_next = (k_dec <= 0) ? cfg_penalty_reg : k_dec[KARMA_W-1:0];
        end else begin
            karma_next = karma_rg;
        end
        meter_next    = meter_chg;
        last_upd_next = regen_go ? in_now_reg : last_upd_reg;
        ever_upd_next = ever_upd_reg || regen_go;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (commit) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_now_reg   <= s_tdata[NOW_W-1:0];
            in_bytes_reg <= s_tdata[NOW_W +: BYTES_W];
        end
    end

    // state update on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            karma_reg    <= INIT_K;
            meter_reg    <= '0;
            last_upd_reg <= '0;
            ever_upd_reg <= 1'b0;
        end else if (commit) begin
            karma_reg    <= karma_next;
            meter_reg    <= meter_next;
            last_upd_reg <= last_upd_next;
            ever_upd_reg <= ever_upd_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_blocked_reg <= (karma_next <= 0);
            out_karma_reg   <= karma_next;
            out_meter_reg   <= meter_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_meter_reg, out_karma_reg, out_blocked_reg};

`ifndef ASSERT_OFF
    // state only moves when a request commits
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(karma_reg) && $stable(meter_reg) && $stable(last_upd_reg))
        else $error("state changed without a commit");

    // a pending result always mirrors the current state
    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_karma_reg == karma_reg) && (out_meter_reg == meter_reg))
        else $error("result register out of step with state");

    // once regenerated, the first-update flag never drops
    a_ever_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ever_upd_reg |=> ever_upd_reg)
        else $error("update flag cleared");
`endif

endmodule

/* verif/karma_rate_limiter_top_test.sv */
`timescale 1ns / 1ps

module karma_rate_limiter_top_test;
    import krl_pkg::*;

    localparam int READ_FACTOR = 100;
    localparam int INIT_KARMA  = 5;
    localparam int CYCLE_LIMIT = 2_000_000;

    // one read request as it sits on s_tdata
    typedef struct packed {
        logic [BYTES_W-1:0] nbytes;
        logic [NOW_W-1:0]   now;
    } read_req_t;

    // predicted limiter verdict for one read
    typedef struct {
        logic               blocked;
        logic [KARMA_W-1:0] karma_now;
        logic [METER_W-1:0] meter_now;
    } verdict_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    read_req_t pending_reads[$];
    verdict_t  expected_verdicts[$];

    // limiter settings as the predictor sees them
    logic [STEP_W-1:0]         max_karma;
    logic [STEP_W-1:0]         inc_step;
    logic [STEP_W-1:0]         dec_step;
    logic signed [KARMA_W-1:0] penalty_val;
    logic signed [KARMA_W-1:0] restore_val;
    logic                      clear_on_restore;
    logic [HB_W-1:0]           hb_secs;

    // connection state as the predictor sees it
    int                 karma_st;
    logic [METER_W-1:0] meter_st;
    logic [NOW_W-1:0]   last_regen;
    bit                 ever_regen;

    bit          idle_on  = 1'b1;
    bit          hold_src = 1'b0;
    int          src_gap  = 0;
    int          sink_gap = 0;
    logic [31:0] tnow;
    int          reads_sent       = 0;
    int          verdicts_checked = 0;
    int          settings_applied = 0;
    int          mismatches       = 0;
    int          cycle_count      = 0;

    karma_rate_limiter_top #(
        .READ_FACTOR(READ_FACTOR),
        .INIT_KARMA (INIT_KARMA)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // heartbeat regeneration, then byte charge; returns the verdict
    function automatic verdict_t predict_read(read_req_t req);
        logic [63:0] due;
        logic [63:0] drain;
        logic [63:0] sum;
        int          k;
        bit          rising;
        verdict_t    v;
        due = {32'd0, last_regen} + {56'd0, hb_secs};
        if (!(ever_regen && due > {32'd0, req.now})) begin
            k = karma_st + int'(inc_step);
            rising = (karma_st < 0) && (k >= 0);
            if (k > int'(max_karma)) k = int'(max_karma);
            karma_st = k;
            if (karma_st > 0) begin
                drain = 64'(karma_st) * 64'(READ_FACTOR);
                meter_st = ({32'd0, meter_st} > drain) ? meter_st - drain[31:0] : '0;
            end
            if (rising) begin
                karma_st = int'(restore_val);
                if (clear_on_restore) meter_st = '0;
            end
            last_regen = req.now;
            ever_regen = 1'b1;
        end
        // meter saturates at all ones
        sum = {32'd0, meter_st} + {48'd0, req.nbytes};
        meter_st = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
        if ($signed({32'd0, meter_st}) > longint'(karma_st * READ_FACTOR)) begin
            k = karma_st - int'(dec_step);
            if (k <= 0) k = int'(penalty_val);
            karma_st = k;
        end
        v.blocked   = (karma_st <= 0);
        v.karma_now = karma_st[7:0];
        v.meter_now = meter_st;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] want, logic [47:0] got);
        $display("MISMATCH result %0d: %s expected 0x%0h got 0x%0h",
                 verdicts_checked, what, want, got);
        mismatches++;
    endtask

    task automatic check_verdict(logic [M_TDATA_W-1:0] got);
        verdict_t want;
        if (expected_verdicts.size() == 0) begin
            report_mismatch("result with nothing outstanding", '0, got);
        end else begin
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (got[0] !== want.blocked)
                report_mismatch("blocked", 48'(want.blocked), 48'(got[0]));
            if (got[8:1] !== want.karma_now)
                report_mismatch("karma_now", 48'(want.karma_now), 48'(got[8:1]));
            if (got[40:9] !== want.meter_now)
                report_mismatch("meter_now", 48'(want.meter_now), 48'(got[40:9]));
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(predict_read(read_req_t'(s_tdata)));
                reads_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (hold_src || pending_reads.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reads.pop_front();
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_verdict(m_tdata);
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_read(logic [NOW_W-1:0] now, logic [BYTES_W-1:0] nbytes);
        read_req_t req;
        req.now    = now;
        req.nbytes = nbytes;
        pending_reads.push_back(req);
    endtask

    // no request on the bus and every result back
    task automatic wait_results();
        @(negedge aclk);
        while (s_tvalid || expected_verdicts.size() != 0) @(negedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_reads.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MAX_KARMA:   max_karma        = val[STEP_W-1:0];
            REG_INC_STEP:    inc_step         = val[STEP_W-1:0];
            REG_DEC_STEP:    dec_step         = val[STEP_W-1:0];
            REG_PENALTY:     penalty_val      = val;
            REG_RESTORE:     restore_val      = val;
            REG_CLEAR_METER: clear_on_restore = val[0];
            REG_HEARTBEAT:   hb_secs          = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int mk, int inc, int dec, int pen, int rest, int clr, int hb);
        write_reg(REG_MAX_KARMA, mk[7:0]);
        write_reg(REG_INC_STEP, inc[7:0]);
        write_reg(REG_DEC_STEP, dec[7:0]);
        write_reg(REG_PENALTY, pen[7:0]);
        write_reg(REG_RESTORE, rest[7:0]);
        write_reg(REG_CLEAR_METER, clr[7:0]);
        write_reg(REG_HEARTBEAT, hb[7:0]);
        settings_applied++;
    endtask

    // mostly forward time with small steps, some heartbeat-sized jumps, rare large jumps,
    // a few reads that step back in time
    task automatic push_random_reads(int count);
        int               pick;
        logic [NOW_W-1:0] when;
        logic [BYTES_W-1:0] nbytes;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) tnow += $urandom_range(0, 3);
            else if (pick < 85) tnow += $urandom_range(0, 2 * hb_secs + 1);
            else if (pick >= 95) tnow += $urandom_range(0, 5000);
            when = (pick >= 85 && pick < 95 && tnow >= 6) ? tnow - $urandom_range(1, 6) : tnow;
            pick = $urandom_range(0, 99);
            if (pick < 45) nbytes = 16'($urandom_range(0, 400));
            else if (pick < 75) nbytes = 16'($urandom_range(0, 2000));
            else if (pick < 95) nbytes = 16'($urandom());
            else nbytes = pick[0] ? 16'hFFFF : 16'h0000;
            queue_read(when, nbytes);
        end
    endtask

    initial begin
        max_karma        = RST_MAX_KARMA;
        inc_step         = RST_INC_STEP;
        dec_step         = RST_DEC_STEP;
        penalty_val      = RST_PENALTY;
        restore_val      = RST_RESTORE;
        clear_on_restore = RST_CLEAR_METER;
        hb_secs          = RST_HEARTBEAT;
        karma_st   = INIT_KARMA;
        meter_st   = '0;
        last_regen = '0;
        ever_regen = 1'b0;
        tnow       = 32'd20;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: first read regenerates, overruns walk karma to the penalty
        queue_read(0, 16'h0000);
        queue_read(0, 16'd700);
        queue_read(1, 16'hFFFF);
        queue_read(2, 16'h0000);
        queue_read(1, 16'd100);
        queue_read(4, 16'hFFFF);
        queue_read(4, 16'hFFFF);
        queue_read(4, 16'h0000);
        queue_read(6, 16'h0000);
        queue_read(9, 16'd300);
        queue_read(11, 16'h0000);
        queue_read(11, 16'h0001);
        wait_drained();

        // zero heartbeat, zero karma cap, positive penalty, restore without clear
        apply_settings(0, 127, 127, 3, -128, 0, 0);
        queue_read(12, 16'h0000);
        queue_read(11, 16'h0000);
        queue_read(11, 16'hFFFF);
        queue_read(13, 16'd250);
        queue_read(13, 16'h0000);
        queue_read(20, 16'h1234);
        wait_drained();

        // upper extremes
        apply_settings(127, 127, 0, -128, 127, 1, 1);
        push_random_reads(90);
        wait_drained();

        // lower extremes, sender held off midway until the results catch up
        apply_settings(1, 0, 127, 0, -128, 0, 255);
        push_random_reads(90);
        @(negedge aclk);
        while (pending_reads.size() > 45) @(negedge aclk);
        hold_src = 1'b1;
        wait_results();
        hold_src = 1'b0;
        wait_drained();

        // increment large enough to climb out of the penalty
        apply_settings(10, 7, 2, -6, 20, 1, 3);
        push_random_reads(90);
        wait_drained();

        apply_settings($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom_range(0, 255));
        push_random_reads(90);
        wait_drained();

        // no idling from here to the end
        idle_on = 1'b0;

        // back to reset settings
        apply_settings(int'(RST_MAX_KARMA), int'(RST_INC_STEP), int'(RST_DEC_STEP),
                       int'(RST_PENALTY), int'(RST_RESTORE), int'(RST_CLEAR_METER),
                       int'(RST_HEARTBEAT));
        push_random_reads(90);
        wait_drained();

        // top of the time range: due time must not wrap
        queue_read(32'hFFFF_FFFE, 16'h8000);
        queue_read(32'hFFFF_FFFF, 16'h7FFF);
        queue_read(5, 16'h0000);
        wait_drained();
        write_reg(REG_HEARTBEAT, 8'd0);
        queue_read(32'hFFFF_FFFF, 16'h0000);
        queue_read(0, 16'hFFFF);
        wait_drained();

        repeat (8) @(posedge aclk);
        $display("%0d reads checked across %0d limiter settings", verdicts_checked,
                 settings_applied);
        $display("covered: heartbeat regen, restore, penalty, backward time, time wrap edge");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/krl_pkg.sv
rtl/core/karma_rate_limiter_top.sv
verif/karma_rate_limiter_top_test.sv
